// File: src/psl_pkg.sv
// ----------------------------------------------------------------------------
// psl_pkg - shared types and constants of the punctuation and string lexer
// Holds the scanner modes, token kinds, character codes and the byte decoder.
// ----------------------------------------------------------------------------
package psl_pkg;

	// scanner modes: idle, comment, and one per kind of held token
	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_SLASH   = 3'd1,
		MODE_COMMENT = 3'd2,
		MODE_STRING  = 3'd3,
		MODE_BANG    = 3'd4,
		MODE_EQUAL   = 3'd5,
		MODE_LESS    = 3'd6,
		MODE_GREATER = 3'd7
	} lex_mode_t;

	localparam int KIND_W = 5;
	localparam int OUT_W  = 16;

	localparam logic [KIND_W-1:0] KIND_LPAREN       = 5'd0;
	localparam logic [KIND_W-1:0] KIND_RPAREN       = 5'd1;
	localparam logic [KIND_W-1:0] KIND_LBRACE       = 5'd2;
	localparam logic [KIND_W-1:0] KIND_RBRACE       = 5'd3;
	localparam logic [KIND_W-1:0] KIND_SEMICOLON    = 5'd4;
	localparam logic [KIND_W-1:0] KIND_COMMA        = 5'd5;
	localparam logic [KIND_W-1:0] KIND_DOT          = 5'd6;
	localparam logic [KIND_W-1:0] KIND_MINUS        = 5'd7;
	localparam logic [KIND_W-1:0] KIND_PLUS         = 5'd8;
	localparam logic [KIND_W-1:0] KIND_SLASH        = 5'd9;
	localparam logic [KIND_W-1:0] KIND_STAR         = 5'd10;
	localparam logic [KIND_W-1:0] KIND_BANG         = 5'd11;
	localparam logic [KIND_W-1:0] KIND_EQUAL        = 5'd13;
	localparam logic [KIND_W-1:0] KIND_LESS         = 5'd15;
	localparam logic [KIND_W-1:0] KIND_GREATER      = 5'd17;
	localparam logic [KIND_W-1:0] KIND_STRING       = 5'd19;
	localparam logic [KIND_W-1:0] KIND_UNEXPECTED   = 5'd20;
	localparam logic [KIND_W-1:0] KIND_UNTERMINATED = 5'd21;
	localparam logic [KIND_W-1:0] KIND_END          = 5'd22;

	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_BANG      = 8'h21;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_PLUS      = 8'h2B;
	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_MINUS     = 8'h2D;
	localparam logic [7:0] CH_DOT       = 8'h2E;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_SEMICOLON = 8'h3B;
	localparam logic [7:0] CH_LESS      = 8'h3C;
	localparam logic [7:0] CH_EQUAL     = 8'h3D;
	localparam logic [7:0] CH_GREATER   = 8'h3E;
	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;

	// output queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [OUT_W-1:0]  offset;
		logic [OUT_W-1:0]  length;
		logic [OUT_W-1:0]  line;
		logic              last;
	} token_t;

	// what one byte does with no token held
	typedef struct packed {
		logic              emit;
		logic [KIND_W-1:0] kind;
		lex_mode_t         mode;
		logic              bump;
	} byte_dec_t;

	function automatic byte_dec_t decode_byte(input logic [7:0] c);
		byte_dec_t d;
		d.emit = 1'b0;
		d.kind = KIND_UNEXPECTED;
		d.mode = MODE_IDLE;
		d.bump = 1'b0;
		unique case (c)
			CH_SPACE, CH_TAB, CH_CR: d.emit = 1'b0;
			CH_NEWLINE:   d.bump = 1'b1;
			CH_LPAREN:    begin d.emit = 1'b1; d.kind = KIND_LPAREN; end
			CH_RPAREN:    begin d.emit = 1'b1; d.kind = KIND_RPAREN; end
			CH_LBRACE:    begin d.emit = 1'b1; d.kind = KIND_LBRACE; end
			CH_RBRACE:    begin d.emit = 1'b1; d.kind = KIND_RBRACE; end
			CH_SEMICOLON: begin d.emit = 1'b1; d.kind = KIND_SEMICOLON; end
			CH_COMMA:     begin d.emit = 1'b1; d.kind = KIND_COMMA; end
			CH_DOT:       begin d.emit = 1'b1; d.kind = KIND_DOT; end
			CH_MINUS:     begin d.emit = 1'b1; d.kind = KIND_MINUS; end
			CH_PLUS:      begin d.emit = 1'b1; d.kind = KIND_PLUS; end
			CH_STAR:      begin d.emit = 1'b1; d.kind = KIND_STAR; end
			CH_SLASH:     d.mode = MODE_SLASH;
			CH_BANG:      d.mode = MODE_BANG;
			CH_EQUAL:     d.mode = MODE_EQUAL;
			CH_LESS:      d.mode = MODE_LESS;
			CH_GREATER:   d.mode = MODE_GREATER;
			CH_QUOTE:     d.mode = MODE_STRING;
			default:      d.emit = 1'b1;
		endcase
		return d;
	endfunction

	// single-character kind of a held operator; the two-character kind is one more
	function automatic logic [KIND_W-1:0] op_kind(input lex_mode_t m);
		logic [KIND_W-1:0] k;
		unique case (m)
			MODE_BANG:    k = KIND_BANG;
			MODE_EQUAL:   k = KIND_EQUAL;
			MODE_LESS:    k = KIND_LESS;
			MODE_GREATER: k = KIND_GREATER;
			default:      k = KIND_SLASH;
		endcase
		return k;
	endfunction

endpackage

// File: src/lox_punctuation_string_lexer.sv
// ----------------------------------------------------------------------------
// lox_punctuation_string_lexer - streaming scanner for punctuation and strings
// Turns a byte stream into tokens with kind, start offset, length and line.
// ----------------------------------------------------------------------------
// One source byte enters per input item (s_tuser low); an item with s_tuser
// high ends the source, flushes any held token, emits an end token and puts
// the scanner back to its reset state. Whitespace and // comments produce no
// tokens; one item produces at most two. The scanner decides each byte in
// the cycle it is taken, so one item is accepted per clock as long as the
// four-entry token queue has room for two more tokens; tokens leave at one
// per clock while m_tready is high, so the sustained rate is one item per cycle
// while items average at most one token each.
// Offsets, lengths and line numbers saturate at 65535 on the output.
module lox_punctuation_string_lexer
	import psl_pkg::*;
#(
	parameter int POSITION_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tuser,   // [0] end_of_source
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [4:0] token_kind, [20:5] token_offset,
	                               // [36:21] token_length, [52:37] token_line, zero pad
	output logic        m_tlast    // last_of_run
);

	localparam int PW = POSITION_WIDTH;
	// wide enough for a position plus one and for the 16-bit clamp test
	localparam int CW = (PW + 1 > OUT_W + 1) ? PW + 1 : OUT_W + 1;

	localparam logic [OUT_W-1:0] LINE_MAX = '1;
	localparam logic [PW-1:0]    POS_MAX  = '1;

	// scanner state
	lex_mode_t         mode_q, mode_d;
	logic [PW-1:0]     pend_q, pend_d;
	logic [PW-1:0]     pos_q, pos_d;
	logic [OUT_W-1:0]  line_q, line_d;

	// token queue
	token_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	logic accept, pop;
	logic [7:0] c;
	logic at_end;
	byte_dec_t dec;

	// up to two tokens per item, first the held one, then the one from this byte
	logic              a_vld, b_vld;
	logic [KIND_W-1:0] a_kind, b_kind;
	logic [PW-1:0]     a_off, b_off;
	logic              a_len_one, a_len_run, b_len_one;
	logic              run_dec, bump;

	logic [CW-1:0]     run_len;
	token_t            tok0, tok1;
	logic [1:0]        n_tok;

	function automatic logic [OUT_W-1:0] clamp16(input logic [CW-1:0] v);
		return (|v[CW-1:OUT_W]) ? LINE_MAX : v[OUT_W-1:0];
	endfunction

	assign c      = s_tdata;
	assign at_end = s_tuser;
	assign accept = s_tvalid && s_tready;
	assign dec    = decode_byte(c);
	// from the held token's start through this byte
	assign run_len = CW'(pos_q) - CW'(pend_q) + CW'(1);

	// next mode and token selection
	always_comb begin
		mode_d    = mode_q;
		a_vld     = 1'b0;
		a_kind    = KIND_SLASH;
		a_off     = pend_q;
		a_len_one = 1'b1;
		a_len_run = 1'b0;
		run_dec   = 1'b0;
		bump      = 1'b0;
		b_vld     = 1'b0;
		b_kind    = KIND_END;
		b_off     = pos_q;
		b_len_one = 1'b0;
		if (at_end) begin
			mode_d = MODE_IDLE;
			unique case (mode_q)
				MODE_IDLE, MODE_COMMENT: a_vld = 1'b0;
				MODE_STRING: begin
					a_vld     = 1'b1;
					a_kind    = KIND_UNTERMINATED;
					a_len_one = 1'b0;
				end
				default: begin
					a_vld  = 1'b1;
					a_kind = op_kind(mode_q);
				end
			endcase
			b_vld = 1'b1;
		end else begin
			unique case (mode_q)
				MODE_IDLE: run_dec = 1'b1;
				MODE_SLASH: begin
					if (c == CH_SLASH) begin
						mode_d = MODE_COMMENT;
					end else begin
						a_vld   = 1'b1;
						run_dec = 1'b1;
					end
				end
				MODE_COMMENT: begin
					if (c == CH_NEWLINE) begin
						mode_d = MODE_IDLE;
						bump   = 1'b1;
					end
				end
				MODE_STRING: begin
					if (c == CH_QUOTE) begin
						mode_d    = MODE_IDLE;
						a_vld     = 1'b1;
						a_kind    = KIND_STRING;
						a_len_one = 1'b0;
						a_len_run = 1'b1;
					end else if (c == CH_NEWLINE) begin
						bump = 1'b1;
					end
				end
				default: begin
					a_vld  = 1'b1;
					mode_d = MODE_IDLE;
					if (c == CH_EQUAL) begin
						a_kind    = op_kind(mode_q) + KIND_W'(1);
						a_len_one = 1'b0;
						a_len_run = 1'b1;
					end else begin
						a_kind  = op_kind(mode_q);
						run_dec = 1'b1;
					end
				end
			endcase
			if (run_dec) begin
				mode_d    = dec.mode;
				bump      = dec.bump;
				b_vld     = dec.emit;
				b_kind    = dec.kind;
				b_len_one = (dec.kind != KIND_UNEXPECTED);
			end
		end
	end

	// state update values
	always_comb begin
		pend_d = pend_q;
		pos_d  = pos_q;
		line_d = line_q;
		if (at_end) begin
			pend_d = '0;
			pos_d  = '0;
			line_d = OUT_W'(1);
		end else begin
			if (run_dec && dec.mode != MODE_IDLE) pend_d = pos_q;
			if (pos_q != POS_MAX) pos_d = pos_q + PW'(1);
			if (bump && line_q != LINE_MAX) line_d = line_q + OUT_W'(1);
		end
	end

	// pack the tokens into queue slots, held token first
	always_comb begin
		token_t ta, tb;
		ta.kind   = a_kind;
		ta.offset = clamp16(CW'(a_off));
		ta.length = a_len_run ? clamp16(run_len) : (a_len_one ? OUT_W'(1) : '0);
		ta.line   = line_q;
		ta.last   = !b_vld;
		tb.kind   = b_kind;
		tb.offset = clamp16(CW'(b_off));
		tb.length = b_len_one ? OUT_W'(1) : '0;
		tb.line   = line_q;
		tb.last   = 1'b1;
		tok0  = a_vld ? ta : tb;
		tok1  = tb;
		n_tok = {1'b0, a_vld} + {1'b0, b_vld};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pend_q <= '0;
			pos_q  <= '0;
			line_q <= OUT_W'(1);
		end else if (accept) begin
			mode_q <= mode_d;
			pend_q <= pend_d;
			pos_q  <= pos_d;
			line_q <= line_d;
		end
	end

	// token queue: up to two writes, one read per cycle
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (count_q != '0);
	// room for the two tokens one item can produce
	assign s_tready = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (accept && n_tok != 2'd0) queue_q[wr_ptr_q] <= tok0;
		if (accept && n_tok == 2'd2) queue_q[wr_ptr_q + QPTR_W'(1)] <= tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) wr_ptr_q <= wr_ptr_q + QPTR_W'(n_tok);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			count_q <= count_q + (accept ? QCNT_W'(n_tok) : '0) - QCNT_W'(pop);
		end
	end

	always_comb begin
		token_t t;
		t       = queue_q[rd_ptr_q];
		m_tdata = {3'b000, t.line, t.length, t.offset, t.kind};
		m_tlast = t.last;
	end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for the punctuation and string lexer
// Streams directed and random source bytes into the scanner, predicts every
// token in the bench and checks each token that leaves the block field by
// field, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb
	import psl_pkg::*;
();

	localparam int GAP_MAX      = 16;
	localparam int QUIET_LIMIT  = 1000;
	localparam int RANDOM_ITEMS = 700;
	localparam int REPORT_MAX   = 10;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_RUN     = 60;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] char_code
	logic        s_tuser;   // [0] end_of_source
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;   // [4:0] kind, [20:5] offset, [36:21] length, [52:37] line
	logic        m_tlast;   // last_of_run

	lox_punctuation_string_lexer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// pacing of both sides, changed per phase
	int src_gap_max;
	int sink_stall_max;

	// tokens still to come out of the block, oldest first
	token_t expected_tokens[$];

	int fail_count;
	int quiet_cycles;

	// scanner state as the bench sees it
	lex_mode_t   lx_mode;
	logic [15:0] lx_start;
	logic [15:0] lx_pos;
	logic [15:0] lx_line;
	int          item_token_count;

	logic [7:0] punct_chars [10] = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
		CH_SEMICOLON, CH_COMMA, CH_DOT, CH_MINUS, CH_PLUS, CH_STAR};
	logic [7:0] op_chars [4] = '{CH_BANG, CH_EQUAL, CH_LESS, CH_GREATER};
	logic [7:0] blank_chars [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_NEWLINE};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// token predictor
	// ------------------------------------------------------------------

	function automatic void next_line();
		if (lx_line != 16'hFFFF)
			lx_line++;
	endfunction

	// queue one expected token; lengths past 16 bits saturate
	function automatic void add_token(input logic [4:0] kind, input logic [15:0] off,
			input logic [16:0] len);
		token_t t;
		t.kind   = kind;
		t.offset = off;
		t.length = (len > 17'h0FFFF) ? 16'hFFFF : len[15:0];
		t.line   = lx_line;
		t.last   = 1'b0;
		expected_tokens.push_back(t);
		item_token_count++;
	endfunction

	// one byte seen with nothing held
	function automatic void scan_plain(input logic [7:0] c, input logic [15:0] off);
		case (c)
			CH_SPACE, CH_TAB, CH_CR: ;
			CH_NEWLINE:   next_line();
			CH_LPAREN:    add_token(KIND_LPAREN, off, 17'd1);
			CH_RPAREN:    add_token(KIND_RPAREN, off, 17'd1);
			CH_LBRACE:    add_token(KIND_LBRACE, off, 17'd1);
			CH_RBRACE:    add_token(KIND_RBRACE, off, 17'd1);
			CH_SEMICOLON: add_token(KIND_SEMICOLON, off, 17'd1);
			CH_COMMA:     add_token(KIND_COMMA, off, 17'd1);
			CH_DOT:       add_token(KIND_DOT, off, 17'd1);
			CH_MINUS:     add_token(KIND_MINUS, off, 17'd1);
			CH_PLUS:      add_token(KIND_PLUS, off, 17'd1);
			CH_STAR:      add_token(KIND_STAR, off, 17'd1);
			CH_SLASH:     begin lx_mode = MODE_SLASH; lx_start = off; end
			CH_BANG:      begin lx_mode = MODE_BANG; lx_start = off; end
			CH_EQUAL:     begin lx_mode = MODE_EQUAL; lx_start = off; end
			CH_LESS:      begin lx_mode = MODE_LESS; lx_start = off; end
			CH_GREATER:   begin lx_mode = MODE_GREATER; lx_start = off; end
			CH_QUOTE:     begin lx_mode = MODE_STRING; lx_start = off; end
			default:      add_token(KIND_UNEXPECTED, off, 17'd0);
		endcase
	endfunction

	// tokens caused by one accepted item, appended to expected_tokens
	function automatic void predict_tokens(input logic [7:0] c, input logic eos);
		logic [4:0]  held_kind;
		logic [16:0] span;
		token_t      t;
		item_token_count = 0;
		// operator modes sit in pairs of kinds starting at the bang
		held_kind = KIND_BANG + ((5'(lx_mode) - 5'(MODE_BANG)) << 1);
		span = {1'b0, lx_pos} - {1'b0, lx_start} + 17'd1;
		if (eos) begin
			case (lx_mode)
				MODE_IDLE, MODE_COMMENT: ;
				MODE_SLASH:  add_token(KIND_SLASH, lx_start, 17'd1);
				MODE_STRING: add_token(KIND_UNTERMINATED, lx_start, 17'd0);
				default:     add_token(held_kind, lx_start, 17'd1);
			endcase
			add_token(KIND_END, lx_pos, 17'd0);
			// whole scanner back to its reset state
			lx_mode  = MODE_IDLE;
			lx_start = '0;
			lx_pos   = '0;
			lx_line  = 16'd1;
		end else begin
			case (lx_mode)
				MODE_IDLE: scan_plain(c, lx_pos);
				MODE_SLASH: begin
					if (c == CH_SLASH) begin
						lx_mode = MODE_COMMENT;
					end else begin
						lx_mode = MODE_IDLE;
						add_token(KIND_SLASH, lx_start, 17'd1);
						scan_plain(c, lx_pos);
					end
				end
				MODE_COMMENT: begin
					if (c == CH_NEWLINE) begin
						lx_mode = MODE_IDLE;
						next_line();
					end
				end
				MODE_STRING: begin
					if (c == CH_QUOTE) begin
						lx_mode = MODE_IDLE;
						add_token(KIND_STRING, lx_start, span);
					end else if (c == CH_NEWLINE) begin
						next_line();
					end
				end
				default: begin
					lx_mode = MODE_IDLE;
					if (c == CH_EQUAL) begin
						add_token(held_kind + 5'd1, lx_start, span);
					end else begin
						add_token(held_kind, lx_start, 17'd1);
						scan_plain(c, lx_pos);
					end
				end
			endcase
			if (lx_pos != 16'hFFFF)
				lx_pos++;
		end
		if (item_token_count > 0) begin
			t = expected_tokens.pop_back();
			t.last = 1'b1;
			expected_tokens.push_back(t);
		end
	endfunction

	// ------------------------------------------------------------------
	// input side: called and returning at a falling edge
	// ------------------------------------------------------------------

	task automatic send_item(input logic [7:0] code, input logic eos);
		int gap;
		gap = $urandom_range(src_gap_max, 0);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= code;
		s_tuser  <= eos;
		do @(posedge clk); while (!s_tready);
		predict_tokens(code, eos);
		@(negedge clk);
	endtask

	task automatic send_text(input string txt);
		for (int i = 0; i < txt.len(); i++)
			send_item(txt[i], 1'b0);
	endtask

	// end item; the byte lane carries junk that must be ignored
	task automatic send_end();
		send_item(8'($urandom_range(255, 0)), 1'b1);
	endtask

	// ------------------------------------------------------------------
	// output side: random stall before each token
	// ------------------------------------------------------------------

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = $urandom_range(sink_stall_max, 0);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// each token leaving the block is matched against the oldest prediction
	always @(posedge clk) begin
		token_t want;
		logic [4:0]  got_kind;
		logic [15:0] got_off, got_len, got_line;
		if (arst_n && m_tvalid && m_tready) begin
			got_kind = m_tdata[4:0];
			got_off  = m_tdata[20:5];
			got_len  = m_tdata[36:21];
			got_line = m_tdata[52:37];
			if (expected_tokens.size() == 0) begin
				if (fail_count < REPORT_MAX)
					$display("%0t: token with none expected: kind %0d off %0d len %0d line %0d last %0b",
						$realtime, got_kind, got_off, got_len, got_line, m_tlast);
				fail_count++;
			end else begin
				want = expected_tokens.pop_front();
				if (got_kind !== want.kind || got_off !== want.offset ||
						got_len !== want.length || got_line !== want.line ||
						m_tlast !== want.last) begin
					if (fail_count < REPORT_MAX) begin
						$display("%0t: token mismatch", $realtime);
						$display("  expected kind %0d off %0d len %0d line %0d last %0b",
							want.kind, want.offset, want.length, want.line, want.last);
						$display("  actual   kind %0d off %0d len %0d line %0d last %0b",
							got_kind, got_off, got_len, got_line, m_tlast);
					end
					fail_count++;
				end
			end
		end
	end

	// watchdog: too long without any item moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// every punctuation kind, each operator alone and with '=', held token
	// followed by a byte that makes a second token
	task automatic test_punctuation_and_operators();
		send_text("!(=)<{>};,.-+/*<=>===!=");
	endtask

	// whitespace, a comment with its newline, a string across two lines
	task automatic test_comments_and_strings();
		send_text(" \r//\t\n\"a\n\"");
	endtask

	// zero byte, letter, digit and top byte are all unexpected
	task automatic test_unexpected_bytes();
		send_item(8'h00, 1'b0);
		send_item(8'h41, 1'b0);
		send_item(8'h37, 1'b0);
		send_item(8'hFF, 1'b0);
	endtask

	// end item in idle, inside a string, after a held operator, after a
	// held slash and inside a comment
	task automatic test_end_of_source();
		send_end();
		send_item(CH_QUOTE, 1'b0);
		send_end();
		send_item(CH_LESS, 1'b0);
		send_end();
		send_item(CH_SLASH, 1'b0);
		send_end();
		send_text("//");
		send_end();
	endtask

	// one string over many lines, sent back to back with no output stalls
	task automatic test_long_string();
		src_gap_max    = 0;
		sink_stall_max = 0;
		send_item(CH_QUOTE, 1'b0);
		repeat (LONG_RUN) send_item(CH_NEWLINE, 1'b0);
		send_item(CH_QUOTE, 1'b0);
		send_item(CH_LPAREN, 1'b0);
		send_item(CH_EQUAL, 1'b0);
		send_end();
	endtask

	// mostly well-formed source words with random content, plus noise
	task automatic test_random_source();
		logic [7:0] word[$];
		logic [7:0] b;
		int sent;
		int body;
		bit end_after;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			// new pacing every few dozen items, with stretches of no idling
			if (sent % 48 < 3) begin
				src_gap_max    = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(GAP_MAX, 1);
				sink_stall_max = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(GAP_MAX, 1);
			end
			word.delete();
			end_after = 1'b0;
			case ($urandom_range(11, 0))
				0, 1, 2: word.push_back(punct_chars[$urandom_range(9, 0)]);
				3, 4: begin
					word.push_back(op_chars[$urandom_range(3, 0)]);
					if ($urandom_range(1, 0))
						word.push_back(CH_EQUAL);
				end
				5: word.push_back(CH_SLASH);
				6: begin
					word.push_back(CH_SLASH);
					word.push_back(CH_SLASH);
					body = $urandom_range(6, 0);
					repeat (body) begin
						do b = 8'($urandom_range(255, 0)); while (b == CH_NEWLINE);
						word.push_back(b);
					end
					word.push_back(CH_NEWLINE);
				end
				7, 8: begin
					word.push_back(CH_QUOTE);
					body = $urandom_range(8, 0);
					repeat (body) begin
						do b = 8'($urandom_range(255, 0)); while (b == CH_QUOTE);
						word.push_back(($urandom_range(7, 0) == 0) ? CH_NEWLINE : b);
					end
					// now and then the source ends inside the string
					if ($urandom_range(4, 0) == 0)
						end_after = 1'b1;
					else
						word.push_back(CH_QUOTE);
				end
				9: word.push_back(blank_chars[$urandom_range(3, 0)]);
				10: word.push_back(8'($urandom_range(255, 0)));
				default: end_after = ($urandom_range(2, 0) == 0);
			endcase
			foreach (word[i])
				send_item(word[i], 1'b0);
			sent += word.size();
			if (end_after) begin
				send_end();
				sent++;
			end
		end
		send_end();
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = 1'b0;
		m_tready       = 1'b0;
		fail_count     = 0;
		quiet_cycles   = 0;
		src_gap_max    = GAP_MAX;
		sink_stall_max = GAP_MAX;
		lx_mode        = MODE_IDLE;
		lx_start       = '0;
		lx_pos         = '0;
		lx_line        = 16'd1;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_punctuation_and_operators();
		test_comments_and_strings();
		test_unexpected_bytes();
		test_end_of_source();
		test_long_string();
		src_gap_max    = GAP_MAX;
		sink_stall_max = GAP_MAX;
		test_random_source();

		s_tvalid <= 1'b0;
		// drain; the watchdog catches tokens that never come
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
